// ===== rtl/core/gbs_pkg.sv =====
package gbs_pkg;

    localparam int COORD_W = 16;
    localparam int EXT_W = COORD_W + 1;
    localparam int AREA_W = 2 * EXT_W;
    localparam int UNION_W = AREA_W + 1;
    localparam int THR_W = 17;
    localparam int PROD_W = THR_W + UNION_W;
    localparam int LHS_W = AREA_W + 16;
    localparam int INDEX_W = 12;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_IOU_ADDR = 2'd0;
    localparam logic [THR_W-1:0] IOU_RESET = 17'd13107;

    typedef struct packed {
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] bottom_y;
        logic               last_box;
    } box_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] box_index;
        logic               kept;
        logic               store_overflow;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
    } corners_t;

    typedef struct packed {
        corners_t           c;
        logic [EXT_W-1:0]   w;
        logic [EXT_W-1:0]   h;
        logic [INDEX_W-1:0] index;
        logic               last;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_FINISH
    } bk_state_t;

    function automatic logic [EXT_W-1:0] extent(input logic [COORD_W-1:0] lo,
                                                input logic [COORD_W-1:0] hi);
        logic [EXT_W-1:0] r;
        if (hi >= lo)
        begin
            r = {1'b0, hi} - {1'b0, lo} + EXT_W'(1);
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/gbs_queue.sv =====
module gbs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gbs_pkg::job_t wdata,
    output logic          full,
    input  logic          pop,
    output gbs_pkg::job_t rdata,
    output logic          empty
);

    gbs_pkg::job_t                     slot_reg [gbs_pkg::QDEPTH];
    logic [gbs_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gbs_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gbs_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push;
    logic                       do_pop;

    assign full    = (count_reg == gbs_pkg::QCNT_W'(gbs_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/core/gbs_front.sv =====
module gbs_front #(
    parameter int MAX_BOXES  = 4096,
    parameter int COORD_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  gbs_pkg::box_in_t box,
    output logic             full,
    output logic             q_push,
    output gbs_pkg::job_t    q_job,
    input  logic             q_full
);

    localparam int CAP_INT = (MAX_BOXES - 1) < 4095 ? (MAX_BOXES - 1) : 4095;
    localparam logic [gbs_pkg::INDEX_W-1:0] INDEX_CAP = gbs_pkg::INDEX_W'(CAP_INT);
    localparam logic [gbs_pkg::COORD_W-1:0] COORD_MASK =
        (COORD_BITS >= gbs_pkg::COORD_W) ? {gbs_pkg::COORD_W{1'b1}}
                                          : gbs_pkg::COORD_W'((32'd1 << COORD_BITS) - 32'd1);

    logic [gbs_pkg::INDEX_W-1:0] index_reg, index_next;
    logic                        accept;
    gbs_pkg::corners_t           c;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept;

    always_comb
    begin
        c.x1 = box.left_x & COORD_MASK;
        c.y1 = box.top_y & COORD_MASK;
        c.x2 = box.right_x & COORD_MASK;
        c.y2 = box.bottom_y & COORD_MASK;
        q_job.c     = c;
        q_job.w     = gbs_pkg::extent(c.x1, c.x2);
        q_job.h     = gbs_pkg::extent(c.y1, c.y2);
        q_job.index = index_reg;
        q_job.last  = box.last_box;
    end

    always_comb
    begin
        index_next = index_reg;
        if (accept)
        begin
            if (box.last_box)
            begin
                index_next = '0;
            end
            else if (index_reg < INDEX_CAP)
            begin
                index_next = index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
        end
        else
        begin
            index_reg <= index_next;
        end
    end

endmodule

// ===== rtl/core/gbs_back.sv =====
module gbs_back #(
    parameter int MAX_KEPT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  gbs_pkg::job_t                 job,
    input  logic [gbs_pkg::THR_W-1:0]     iou_threshold,
    output logic                          res_valid,
    input  logic                          res_pop,
    output gbs_pkg::result_t              result
);

    localparam int KW = $clog2(MAX_KEPT + 1);
    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    gbs_pkg::bk_state_t state_reg, state_next;
    gbs_pkg::job_t      cur_reg, cur_next;
    logic [KW-1:0]      scan_reg, scan_next;
    logic [KW-1:0]      kept_total_reg, kept_total_next;
    logic [KW-1:0]      scan_inc;
    logic               suppress_reg, suppress_next;
    gbs_pkg::result_t   res_reg, res_next;
    logic               res_valid_reg, res_valid_next;
    logic [4:0]         pipe_v_reg;
    logic               issue;
    logic               finish_fire;
    logic               keep;
    logic               overflow;
    logic               store_we;
    logic               hit;

    gbs_pkg::corners_t  store [MAX_KEPT];
    gbs_pkg::corners_t  rd_box_reg;

    logic [gbs_pkg::AREA_W-1:0]  cur_area_reg;
    logic [gbs_pkg::EXT_W-1:0]   wi_reg, hi_reg, wk_reg, hk_reg;
    logic [gbs_pkg::AREA_W-1:0]  inter3_reg, areak_reg;
    logic [gbs_pkg::AREA_W-1:0]  inter4_reg;
    logic [gbs_pkg::UNION_W-1:0] union_reg;
    logic [gbs_pkg::PROD_W-1:0]  prod_reg;
    logic [gbs_pkg::LHS_W-1:0]   lhs_reg;
    logic                        unz_reg;
    logic [gbs_pkg::COORD_W-1:0] lx, ty, rx, by;

    assign res_valid = res_valid_reg;
    assign result    = res_reg;
    assign issue     = (state_reg == gbs_pkg::BK_SCAN);
    assign scan_inc  = scan_reg + 1'b1;
    assign keep      = !suppress_reg;
    assign overflow  = keep && (kept_total_reg == KW'(MAX_KEPT));
    assign hit       = unz_reg && ({{(gbs_pkg::PROD_W - gbs_pkg::LHS_W){1'b0}}, lhs_reg}
                                   >= prod_reg);

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        scan_next       = scan_reg;
        suppress_next   = suppress_reg;
        kept_total_next = kept_total_reg;
        res_next        = res_reg;
        q_pop           = 1'b0;
        finish_fire     = 1'b0;
        store_we        = 1'b0;
        if (pipe_v_reg[4] && hit)
        begin
            suppress_next = 1'b1;
        end
        case (state_reg)
            gbs_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    cur_next      = job;
                    scan_next     = '0;
                    suppress_next = 1'b0;
                    state_next    = (kept_total_reg != '0) ? gbs_pkg::BK_SCAN
                                                           : gbs_pkg::BK_FINISH;
                end
            end
            gbs_pkg::BK_SCAN:
            begin
                scan_next = scan_inc;
                if (scan_inc == kept_total_reg)
                begin
                    state_next = gbs_pkg::BK_DRAIN;
                end
            end
            gbs_pkg::BK_DRAIN:
            begin
                if (pipe_v_reg == '0)
                begin
                    state_next = gbs_pkg::BK_FINISH;
                end
            end
            gbs_pkg::BK_FINISH:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    finish_fire             = 1'b1;
                    store_we                = keep && !overflow;
                    res_next.box_index      = cur_reg.index;
                    res_next.kept           = keep;
                    res_next.store_overflow = overflow;
                    res_next.last_result    = cur_reg.last;
                    if (cur_reg.last)
                    begin
                        kept_total_next = '0;
                    end
                    else if (store_we)
                    begin
                        kept_total_next = kept_total_reg + 1'b1;
                    end
                    state_next = gbs_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = gbs_pkg::BK_IDLE;
            end
        endcase
        res_valid_next = finish_fire ? 1'b1 : (res_pop ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gbs_pkg::BK_IDLE;
            scan_reg       <= '0;
            kept_total_reg <= '0;
            suppress_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            pipe_v_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            kept_total_reg <= kept_total_next;
            suppress_reg   <= suppress_next;
            res_valid_reg  <= res_valid_next;
            pipe_v_reg     <= {pipe_v_reg[3:0], issue};
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store[kept_total_reg[AW-1:0]] <= cur_reg.c;
        end
        rd_box_reg <= store[scan_reg[AW-1:0]];
    end

    always_comb
    begin
        lx = (rd_box_reg.x1 > cur_reg.c.x1) ? rd_box_reg.x1 : cur_reg.c.x1;
        ty = (rd_box_reg.y1 > cur_reg.c.y1) ? rd_box_reg.y1 : cur_reg.c.y1;
        rx = (rd_box_reg.x2 < cur_reg.c.x2) ? rd_box_reg.x2 : cur_reg.c.x2;
        by = (rd_box_reg.y2 < cur_reg.c.y2) ? rd_box_reg.y2 : cur_reg.c.y2;
    end

    always_ff @(posedge clk)
    begin
        cur_area_reg <= cur_reg.w * cur_reg.h;
        wi_reg       <= gbs_pkg::extent(lx, rx);
        hi_reg       <= gbs_pkg::extent(ty, by);
        wk_reg       <= gbs_pkg::extent(rd_box_reg.x1, rd_box_reg.x2);
        hk_reg       <= gbs_pkg::extent(rd_box_reg.y1, rd_box_reg.y2);
        inter3_reg   <= wi_reg * hi_reg;
        areak_reg    <= wk_reg * hk_reg;
        union_reg    <= {1'b0, areak_reg} + {1'b0, cur_area_reg} - {1'b0, inter3_reg};
        inter4_reg   <= inter3_reg;
        prod_reg     <= iou_threshold * union_reg;
        lhs_reg      <= {inter4_reg, 16'd0};
        unz_reg      <= (union_reg != '0);
    end

endmodule

// ===== rtl/core/greedy_box_suppression_top.sv =====
// A box's result follows a scan over K stored boxes, K being the number of kept
// boxes stored for the current set (at most MAX_KEPT); the scan is skipped when none is stored.
// One box is judged at a time, the next being taken from the queue once the current result is
// registered; the kept box memory's single read port delivers one stored box per cycle to the pipeline.
// Reset is asynchronous and active low; it empties the queue and the result register,
// clears the kept count and box index, and sets the threshold to 13107.
module greedy_box_suppression_top #(
    parameter int MAX_KEPT   = 256,
    parameter int MAX_BOXES  = 4096,
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  gbs_pkg::box_in_t                 box,
    output logic                             empty,
    input  logic                             pop,
    output gbs_pkg::result_t                 result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gbs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gbs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gbs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [gbs_pkg::THR_W-1:0] thr_reg, thr_next;
    logic                      q_push;
    logic                      q_full;
    logic                      q_pop;
    logic                      q_empty;
    gbs_pkg::job_t             q_wjob;
    gbs_pkg::job_t             q_rjob;
    logic                      res_valid;
    logic                      res_pop;

    assign pready  = 1'b1;
    assign prdata  = {{(gbs_pkg::APB_DATA_W - gbs_pkg::THR_W){1'b0}}, thr_reg};
    assign empty   = !res_valid;
    assign res_pop = pop && res_valid;

    always_comb
    begin
        thr_next = thr_reg;
        if (psel && penable && pwrite && pready && (paddr == gbs_pkg::REG_IOU_ADDR))
        begin
            thr_next = pwdata[gbs_pkg::THR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= gbs_pkg::IOU_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    gbs_front #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .box    (box),
        .full   (full),
        .q_push (q_push),
        .q_job  (q_wjob),
        .q_full (q_full)
    );

    gbs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wjob),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rjob),
        .empty (q_empty)
    );

    gbs_back #(
        .MAX_KEPT (MAX_KEPT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .job           (q_rjob),
        .iou_threshold (thr_reg),
        .res_valid     (res_valid),
        .res_pop       (res_pop),
        .result        (result)
    );

    a_overflow_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.store_overflow) |-> result.kept)
        else $error("Overflow reported on a suppressed box.");

    a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("Item pushed into a full queue.");

    a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("Item popped from an empty queue.");

    a_thr_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr == gbs_pkg::REG_IOU_ADDR))
        |=> (prdata[gbs_pkg::THR_W-1:0] == $past(pwdata[gbs_pkg::THR_W-1:0])))
        else $error("Threshold register did not take the written value.");

endmodule

// ===== tb/tb_greedy_box_suppression_top.sv =====
module tb_greedy_box_suppression_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEPT_DEPTH   = 256;
    localparam int INDEX_TOP    = 4095;
    localparam int RANDOM_ITEMS = 165;
    localparam int STEADY_FROM  = 60;
    localparam int STEADY_TO    = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int IDLE_PERCENT = 10;
    localparam int REPORT_LIMIT = 10;

    localparam logic [gbs_pkg::THR_W-1:0] THR_ONE = 17'd65536;

    typedef enum logic {
        STEP_BOX,
        STEP_THRESHOLD
    } step_kind_t;

    typedef struct packed {
        step_kind_t                  kind;
        gbs_pkg::box_in_t            b;
        logic [gbs_pkg::THR_W-1:0]   thr;
        logic                        typed;
        gbs_pkg::result_t            want;
    } plan_step_t;

    logic                           clk     = 1'b0;
    logic                           rst_n   = 1'b0;
    logic                           push    = 1'b0;
    gbs_pkg::box_in_t               box     = '0;
    logic                           pop     = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [gbs_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [gbs_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic                           full;
    logic                           empty;
    gbs_pkg::result_t               result;
    logic [gbs_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    bit               steady      = 1'b0;
    bit               hold_go     = 1'b0;
    int unsigned      held_cycles = 0;
    bit               use_typed   = 1'b0;
    gbs_pkg::result_t typed_want  = '0;

    gbs_pkg::corners_t         kept_corners [KEPT_DEPTH];
    int unsigned               kept_count = 0;
    int unsigned               next_index = 0;
    logic [gbs_pkg::THR_W-1:0] thr_now    = gbs_pkg::IOU_RESET;
    gbs_pkg::result_t          expected_verdicts [$];
    gbs_pkg::result_t          fresh;
    gbs_pkg::result_t          oldest;
    plan_step_t                plan [$];

    int unsigned errors       = 0;
    int unsigned boxes_in     = 0;
    int unsigned sets_done    = 0;
    int unsigned kept_n       = 0;
    int unsigned suppressed_n = 0;
    int unsigned overflow_n   = 0;
    int unsigned thr_writes   = 0;

    greedy_box_suppression_top #(
        .MAX_KEPT   (KEPT_DEPTH),
        .MAX_BOXES  (4096),
        .COORD_BITS (gbs_pkg::COORD_W)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .box     (box),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    function automatic void add_step(input plan_step_t s);
        plan.insert(plan.size(), s);
    endfunction

    function automatic void expect_item(input gbs_pkg::result_t r);
        expected_verdicts.insert(expected_verdicts.size(), r);
    endfunction

    function automatic longint unsigned span(input logic [gbs_pkg::COORD_W-1:0] lo,
                                             input logic [gbs_pkg::COORD_W-1:0] hi);
        if (hi >= lo)
        begin
            return 64'(hi) - 64'(lo) + 64'd1;
        end
        return 64'd0;
    endfunction

    // Greedy suppression of one box against the boxes kept so far in its set.
    function automatic gbs_pkg::result_t judge_box(input gbs_pkg::box_in_t b);
        gbs_pkg::corners_t           c;
        gbs_pkg::result_t            r;
        logic                        keep;
        logic [gbs_pkg::COORD_W-1:0] lo_x, lo_y, hi_x, hi_y;
        longint unsigned             inter, uni;
        c.x1 = b.left_x;
        c.y1 = b.top_y;
        c.x2 = b.right_x;
        c.y2 = b.bottom_y;
        keep = 1'b1;
        for (int unsigned k = 0; k < kept_count && keep; k++)
        begin
            lo_x = (kept_corners[k].x1 > c.x1) ? kept_corners[k].x1 : c.x1;
            lo_y = (kept_corners[k].y1 > c.y1) ? kept_corners[k].y1 : c.y1;
            hi_x = (kept_corners[k].x2 < c.x2) ? kept_corners[k].x2 : c.x2;
            hi_y = (kept_corners[k].y2 < c.y2) ? kept_corners[k].y2 : c.y2;
            inter = span(lo_x, hi_x) * span(lo_y, hi_y);
            uni = span(kept_corners[k].x1, kept_corners[k].x2)
                * span(kept_corners[k].y1, kept_corners[k].y2)
                + span(c.x1, c.x2) * span(c.y1, c.y2) - inter;
            if (uni != 0 && inter * 64'd65536 >= 64'(thr_now) * uni)
            begin
                keep = 1'b0;
            end
        end
        r.box_index      = gbs_pkg::INDEX_W'(next_index);
        r.kept           = keep;
        r.store_overflow = keep && (kept_count >= KEPT_DEPTH);
        r.last_result    = b.last_box;
        if (keep && kept_count < KEPT_DEPTH)
        begin
            kept_corners[kept_count] = c;
            kept_count++;
        end
        if (b.last_box)
        begin
            kept_count = 0;
            next_index = 0;
        end
        else if (next_index < INDEX_TOP)
        begin
            next_index++;
        end
        return r;
    endfunction

    function automatic gbs_pkg::box_in_t make_box(input int unsigned cx, input int unsigned cy);
        gbs_pkg::box_in_t b;
        int unsigned      roll, x, y, w, h;
        roll = $urandom_range(0, 99);
        x = cx + $urandom_range(0, 48);
        y = cy + $urandom_range(0, 48);
        w = $urandom_range(0, 200);
        h = $urandom_range(0, 200);
        b = '0;
        if (roll < 70)
        begin
            b.left_x   = 16'(x);
            b.top_y    = 16'(y);
            b.right_x  = 16'(x + w);
            b.bottom_y = 16'(y + h);
        end
        else if (roll < 85)
        begin
            b.left_x   = 16'($urandom);
            b.top_y    = 16'($urandom);
            b.right_x  = 16'($urandom);
            b.bottom_y = 16'($urandom);
        end
        else if (roll < 95)
        begin
            b.left_x   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            b.top_y    = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            b.right_x  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            b.bottom_y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        else
        begin
            b.left_x   = 16'(x + w + 1);
            b.top_y    = 16'(y);
            b.right_x  = 16'(x);
            b.bottom_y = 16'(y + h);
        end
        return b;
    endfunction

    function automatic plan_step_t box_step(input int unsigned x1, input int unsigned y1,
                                            input int unsigned x2, input int unsigned y2,
                                            input bit last, input bit typed,
                                            input int unsigned idx, input bit kept);
        plan_step_t s;
        s            = '0;
        s.kind       = STEP_BOX;
        s.b.left_x   = 16'(x1);
        s.b.top_y    = 16'(y1);
        s.b.right_x  = 16'(x2);
        s.b.bottom_y = 16'(y2);
        s.b.last_box = last;
        s.typed      = typed;
        s.want.box_index   = gbs_pkg::INDEX_W'(idx);
        s.want.kept        = kept;
        s.want.last_result = last;
        return s;
    endfunction

    function automatic plan_step_t thr_step(input logic [gbs_pkg::THR_W-1:0] v);
        plan_step_t s;
        s      = '0;
        s.kind = STEP_THRESHOLD;
        s.thr  = v;
        return s;
    endfunction

    task automatic offer(input gbs_pkg::box_in_t b);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        box  <= b;
        do @(posedge clk); while (full);
    endtask

    task automatic apb_access(input logic wr, input logic [gbs_pkg::APB_DATA_W-1:0] wdata,
                              output logic [gbs_pkg::APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= gbs_pkg::REG_IOU_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_threshold(input logic [gbs_pkg::THR_W-1:0] want);
        logic [gbs_pkg::APB_DATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== gbs_pkg::APB_DATA_W'(want))
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
            begin
                $display("Threshold register reads %0d, expected %0d.", rd, want);
            end
        end
    endtask

    // The threshold only changes once every box sent so far has been answered.
    task automatic write_threshold(input logic [gbs_pkg::THR_W-1:0] v);
        logic [gbs_pkg::APB_DATA_W-1:0] rd;
        push <= 1'b0;
        do @(negedge clk); while (expected_verdicts.size() != 0);
        @(posedge clk);
        apb_access(1'b1, gbs_pkg::APB_DATA_W'(v), rd);
        thr_now <= v;
        thr_writes++;
        read_threshold(v);
    endtask

    always @(posedge clk)
    begin
        if (hold_go && held_cycles < HOLD_CYCLES)
        begin
            held_cycles <= held_cycles + 1;
            pop         <= 1'b0;
        end
        else
        begin
            pop <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                    begin
                        $display("Unexpected result item: index %0d kept %0b overflow %0b",
                                 result.box_index, result.kept, result.store_overflow);
                    end
                end
                else
                begin
                    oldest = expected_verdicts.pop_front();
                    if (result.box_index !== oldest.box_index || result.kept !== oldest.kept
                        || result.store_overflow !== oldest.store_overflow
                        || result.last_result !== oldest.last_result)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                        begin
                            $write("Mismatch: expected index %0d kept %0b overflow %0b last %0b, ",
                                   oldest.box_index, oldest.kept, oldest.store_overflow,
                                   oldest.last_result);
                            $display("got index %0d kept %0b overflow %0b last %0b.",
                                     result.box_index, result.kept,
                                     result.store_overflow, result.last_result);
                        end
                    end
                end
            end
            if (push && !full)
            begin
                fresh = judge_box(box);
                boxes_in++;
                sets_done    += fresh.last_result;
                kept_n       += fresh.kept;
                suppressed_n += !fresh.kept;
                overflow_n   += fresh.store_overflow;
                if (use_typed)
                begin
                    fresh = typed_want;
                end
                expect_item(fresh);
            end
        end
    end

    initial
    begin
        gbs_pkg::box_in_t          b;
        gbs_pkg::box_in_t          first_kept;
        logic [gbs_pkg::THR_W-1:0] thr_pick;
        int unsigned               random_sent;
        int unsigned               set_len;
        int unsigned               phase;
        int unsigned               cx [2];
        int unsigned               cy [2];

        add_step(box_step(0, 0, 0, 0, 0, 1, 0, 1));
        add_step(box_step(0, 0, 0, 0, 0, 1, 1, 0));
        add_step(box_step(65535, 65535, 65535, 65535, 0, 1, 2, 1));
        add_step(box_step(0, 0, 65535, 65535, 0, 1, 3, 1));
        add_step(box_step(10, 10, 5, 5, 0, 0, 0, 0));
        add_step(box_step(20, 20, 3, 3, 0, 0, 0, 0));
        add_step(box_step(65535, 0, 0, 65535, 1, 0, 0, 0));
        add_step(box_step(100, 100, 199, 199, 0, 1, 0, 1));
        add_step(box_step(100, 100, 199, 199, 0, 1, 1, 0));
        add_step(box_step(150, 100, 249, 199, 0, 0, 0, 0));
        add_step(box_step(190, 100, 289, 199, 1, 0, 0, 0));
        add_step(thr_step('0));
        add_step(box_step(0, 0, 9, 9, 0, 1, 0, 1));
        add_step(box_step(9, 9, 18, 18, 0, 0, 0, 0));
        add_step(box_step(50, 50, 59, 59, 1, 0, 0, 0));
        add_step(thr_step(THR_ONE));
        add_step(box_step(0, 0, 9, 9, 0, 1, 0, 1));
        add_step(box_step(0, 0, 9, 8, 0, 0, 0, 0));
        add_step(box_step(0, 0, 9, 9, 1, 1, 2, 0));
        add_step(thr_step(gbs_pkg::IOU_RESET));
        add_step(box_step(5, 5, 5, 5, 1, 1, 0, 1));
        add_step(box_step(5, 5, 5, 5, 0, 1, 0, 1));
        add_step(box_step(5, 5, 5, 5, 1, 1, 1, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_threshold(gbs_pkg::IOU_RESET);

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_THRESHOLD)
            begin
                write_threshold(plan[i].thr);
            end
            else
            begin
                use_typed  <= plan[i].typed;
                typed_want <= plan[i].want;
                offer(plan[i].b);
            end
        end
        use_typed <= 1'b0;

        // Random sets; the first one runs into a long stall on the result side.
        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0: thr_pick = '0;
                1: thr_pick = THR_ONE;
                2: thr_pick = gbs_pkg::IOU_RESET;
                3: thr_pick = 17'd32768;
                4: thr_pick = 17'd65535;
                default: thr_pick = 17'($urandom_range(0, 65536));
            endcase
            write_threshold(thr_pick);
            set_len = $urandom_range(1, 40);
            if (phase == 0)
            begin
                set_len = 40;
                hold_go <= 1'b1;
            end
            if (set_len > RANDOM_ITEMS - random_sent)
            begin
                set_len = RANDOM_ITEMS - random_sent;
            end
            for (int k = 0; k < 2; k++)
            begin
                cx[k] = $urandom_range(0, 65280);
                cy[k] = $urandom_range(0, 65280);
            end
            for (int i = 0; i < set_len; i++)
            begin
                b = make_box(cx[i % 2], cy[i % 2]);
                b.last_box = (i == set_len - 1);
                offer(b);
                random_sent++;
                if (random_sent == STEADY_FROM)
                begin
                    steady <= 1'b1;
                end
                else if (random_sent == STEADY_TO)
                begin
                    steady <= 1'b0;
                end
            end
            phase++;
        end

        // Fill the kept store with disjoint boxes, then run past its end.
        write_threshold(THR_ONE);
        first_kept = '0;
        for (int i = 0; i < KEPT_DEPTH + 5; i++)
        begin
            if (i < KEPT_DEPTH)
            begin
                b.left_x   = 16'((i % 16) * 4096 + $urandom_range(0, 2047));
                b.right_x  = b.left_x + 16'($urandom_range(0, 2047));
                b.top_y    = 16'((i / 16) * 4096 + $urandom_range(0, 2047));
                b.bottom_y = b.top_y + 16'($urandom_range(0, 2047));
            end
            else if (i == KEPT_DEPTH)
            begin
                b = first_kept;
            end
            else
            begin
                b = make_box($urandom_range(0, 65280), $urandom_range(0, 65280));
            end
            b.last_box = (i == KEPT_DEPTH + 4);
            if (i == 0)
            begin
                first_kept = b;
            end
            offer(b);
        end

        push <= 1'b0;
        do @(negedge clk); while (expected_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d boxes in %0d sets: %0d kept, %0d suppressed.",
                 boxes_in, sets_done, kept_n, suppressed_n);
        $display("%0d boxes kept with the store full; threshold written %0d times.",
                 overflow_n, thr_writes);
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
